### rtl/hdrf_pkg.sv
package hdrf_pkg;

  localparam int PIX_W   = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 8;
  localparam int W_W     = 17;               // Q1.16 weight
  localparam int OUT_W   = 15;
  localparam int GAUSS_N = 256;
  localparam int K_W     = 8;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SHORT_CLIP = 8'd0,
    REG_LONG_DARK  = 8'd1,
    REG_MED_MID    = 8'd2,
    REG_MED_SPREAD = 8'd3
  } reg_idx_t;

  localparam logic [CFG_W-1:0] RST_SHORT_CLIP = 16'd60000;
  localparam logic [CFG_W-1:0] RST_LONG_DARK  = 16'd5000;
  localparam logic [CFG_W-1:0] RST_MED_MID    = 16'd32768;
  localparam logic [CFG_W-1:0] RST_MED_SPREAD = 16'd16384;

  localparam logic [63:0] EXP_STEP = 64'd4162825044;

  typedef logic [W_W-1:0] gauss_tab_t [GAUSS_N];

  // exp(-k/32) in Q1.16, built by the fixed-point recurrence
  function automatic gauss_tab_t gauss_build();
    gauss_tab_t  tab;
    logic [63:0] a;
    logic [63:0] e;
    a = 64'd1 << 30;
    for (int k = 0; k < GAUSS_N; k++) begin
      e = (a + (64'd1 << 13)) >> 14;
      tab[k] = e[W_W-1:0];
      a = (a * EXP_STEP) >> 32;
    end
    return tab;
  endfunction

  localparam gauss_tab_t GAUSS_TAB = gauss_build();

  // Per-pixel data carried alongside the Gaussian index divider
  typedef struct packed {
    logic [W_W-1:0]   ws;
    logic [W_W-1:0]   wl;
    logic [PIX_W-1:0] s;
    logic [PIX_W-1:0] m;
    logic [PIX_W-1:0] l;
  } side_t;

endpackage

### rtl/three_exposure_hdr_fusion_core.sv
// Three-exposure HDR fusion: one fused, tone-compressed pixel per item.
// Input: drive in_short_pixel, in_medium_pixel, in_long_pixel with start
// high; the item is taken on any edge with start high and busy low. busy
// is always low, so a new item may enter every clock.
// Output: out_valid pulses for one cycle with out_fused_pixel; the
// receiver cannot stall, so results are never held back.
// Throughput is one item per clock. Most of the pipeline depth comes
// from two pipelined restoring dividers: the Gaussian index (8 quotient
// bits, 2 per stage) and the final normalize-and-compress divide (15 bits,
// 3 per stage).
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
// is always high. Write only while no items are in flight. Indexes
// above 3 are ignored.
// Reset (synchronous, rst_n low) empties the pipeline and restores the
// register defaults; no result emerges for items taken before reset.
module three_exposure_hdr_fusion_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [hdrf_pkg::PIX_W-1:0]  in_short_pixel,
  input  logic [hdrf_pkg::PIX_W-1:0]  in_medium_pixel,
  input  logic [hdrf_pkg::PIX_W-1:0]  in_long_pixel,
  output logic                        out_valid,
  output logic [hdrf_pkg::OUT_W-1:0]  out_fused_pixel,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hdrf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [hdrf_pkg::CFG_W-1:0]  cfg_data
);
  import hdrf_pkg::*;

  localparam int KD_STAGES = 4;
  localparam int FD_STAGES = 5;
  localparam int KD_BITS   = 2;
  localparam int FD_BITS   = 3;
  localparam int KR_W      = 40;
  localparam int FR_W      = 51;
  localparam int DEN_W     = 36;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers
  logic [CFG_W-1:0] clip_r, dark_r, mid_r, spread_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r   <= RST_SHORT_CLIP;
      dark_r   <= RST_LONG_DARK;
      mid_r    <= RST_MED_MID;
      spread_r <= RST_MED_SPREAD;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SHORT_CLIP: clip_r   <= cfg_data;
        REG_LONG_DARK:  dark_r   <= cfg_data;
        REG_MED_MID:    mid_r    <= cfg_data;
        REG_MED_SPREAD: spread_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // Stage 1: linear weights, distance from midpoint
  side_t            side1_r, side1_nxt;
  logic [PIX_W-1:0] d1_r, d1_nxt, sp1_r, sp1_nxt;

  always_comb begin
    side1_nxt.s  = in_short_pixel;
    side1_nxt.m  = in_medium_pixel;
    side1_nxt.l  = in_long_pixel;
    // floor(x*65536/65535) = x + (x == 65535)
    side1_nxt.ws = '0;
    if (in_short_pixel < clip_r)
      side1_nxt.ws = {1'b0, ~in_short_pixel} + W_W'(in_short_pixel == '0);
    side1_nxt.wl = '0;
    if (in_long_pixel > dark_r)
      side1_nxt.wl = {1'b0, in_long_pixel} + W_W'(&in_long_pixel);
    d1_nxt  = (in_medium_pixel >= mid_r) ? in_medium_pixel - mid_r
                                         : mid_r - in_medium_pixel;
    sp1_nxt = (spread_r == '0) ? PIX_W'(1) : spread_r;
  end

  // Stage 2: squares
  side_t              side2_r;
  logic [2*PIX_W-1:0] d2_r, sp2_r;

  // Gaussian index divider stages
  side_t              kd_side_r [KD_STAGES];
  logic [KR_W-1:0]    kd_rem_r  [KD_STAGES];
  logic [2*PIX_W-1:0] kd_sp_r   [KD_STAGES];
  logic [K_W-1:0]     kd_q_r    [KD_STAGES];
  logic               kd_sat_r  [KD_STAGES];
  logic [KR_W-1:0]    kd_rem_nxt [KD_STAGES];
  logic [K_W-1:0]     kd_q_nxt   [KD_STAGES];
  logic               kd_sat_nxt [KD_STAGES];

  always_comb begin
    for (int j = 0; j < KD_STAGES; j++) begin
      logic [KR_W-1:0] rem;
      logic [K_W-1:0]  q;
      logic [KR_W-1:0] dv;
      if (j == 0) begin
        rem = KR_W'({d2_r, 5'b0});
        q   = '0;
        kd_sat_nxt[j] = {3'b0, d2_r} >= {sp2_r, 3'b0};
        dv  = KR_W'(sp2_r);
      end else begin
        rem = kd_rem_r[j-1];
        q   = kd_q_r[j-1];
        kd_sat_nxt[j] = kd_sat_r[j-1];
        dv  = KR_W'(kd_sp_r[j-1]);
      end
      for (int b = 0; b < KD_BITS; b++) begin
        if (rem >= (dv << (K_W - 1 - KD_BITS*j - b))) begin
          rem = rem - (dv << (K_W - 1 - KD_BITS*j - b));
          q[K_W - 1 - KD_BITS*j - b] = 1'b1;
        end
      end
      kd_rem_nxt[j] = rem;
      kd_q_nxt[j]   = q;
    end
  end

  // Table lookup stage
  side_t          sidet_r;
  logic [W_W-1:0] wm_r;
  logic [K_W-1:0] kidx;
  assign kidx = kd_sat_r[KD_STAGES-1] ? K_W'(GAUSS_N - 1) : kd_q_r[KD_STAGES-1];

  // Product stage
  logic [W_W+PIX_W-1:0] ps_r, pm_r, pl_r;
  logic [W_W+1:0]       t_r;

  // Sum stage: numerator 65535*N, denominator 65535*T + N
  logic [DEN_W-1:0] n_sum, den_nxt, den_r;
  logic [FR_W-1:0]  num_nxt, num_r;
  assign n_sum   = DEN_W'(ps_r) + DEN_W'(pm_r) + DEN_W'(pl_r);
  assign den_nxt = (DEN_W'(t_r) << PIX_W) - DEN_W'(t_r) + n_sum;
  assign num_nxt = (FR_W'(n_sum) << PIX_W) - FR_W'(n_sum);

  // Final divider stages
  logic [FR_W-1:0]  fd_rem_r [FD_STAGES];
  logic [DEN_W-1:0] fd_den_r [FD_STAGES];
  logic [OUT_W-1:0] fd_q_r   [FD_STAGES];
  logic [FR_W-1:0]  fd_rem_nxt [FD_STAGES];
  logic [OUT_W-1:0] fd_q_nxt   [FD_STAGES];

  always_comb begin
    for (int j = 0; j < FD_STAGES; j++) begin
      logic [FR_W-1:0]  rem;
      logic [OUT_W-1:0] q;
      logic [FR_W-1:0]  dv;
      if (j == 0) begin
        rem = num_r;
        q   = '0;
        dv  = FR_W'(den_r);
      end else begin
        rem = fd_rem_r[j-1];
        q   = fd_q_r[j-1];
        dv  = FR_W'(fd_den_r[j-1]);
      end
      for (int b = 0; b < FD_BITS; b++) begin
        if (rem >= (dv << (OUT_W - 1 - FD_BITS*j - b))) begin
          rem = rem - (dv << (OUT_W - 1 - FD_BITS*j - b));
          q[OUT_W - 1 - FD_BITS*j - b] = 1'b1;
        end
      end
      fd_rem_nxt[j] = rem;
      fd_q_nxt[j]   = q;
    end
  end

  // Valid bits
  logic v1_r, v2_r, vt_r, vp_r, vn_r;
  logic kd_v_r [KD_STAGES];
  logic fd_v_r [FD_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vt_r <= 1'b0;
      vp_r <= 1'b0;
      vn_r <= 1'b0;
      for (int j = 0; j < KD_STAGES; j++) kd_v_r[j] <= 1'b0;
      for (int j = 0; j < FD_STAGES; j++) fd_v_r[j] <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      kd_v_r[0] <= v2_r;
      for (int j = 1; j < KD_STAGES; j++) kd_v_r[j] <= kd_v_r[j-1];
      vt_r <= kd_v_r[KD_STAGES-1];
      vp_r <= vt_r;
      vn_r <= vp_r;
      fd_v_r[0] <= vn_r;
      for (int j = 1; j < FD_STAGES; j++) fd_v_r[j] <= fd_v_r[j-1];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    side1_r <= side1_nxt;
    d1_r    <= d1_nxt;
    sp1_r   <= sp1_nxt;

    side2_r <= side1_r;
    d2_r    <= d1_r * d1_r;
    sp2_r   <= sp1_r * sp1_r;

    for (int j = 0; j < KD_STAGES; j++) begin
      kd_side_r[j] <= (j == 0) ? side2_r : kd_side_r[(j == 0) ? 0 : j-1];
      kd_sp_r[j]   <= (j == 0) ? sp2_r : kd_sp_r[(j == 0) ? 0 : j-1];
      kd_rem_r[j]  <= kd_rem_nxt[j];
      kd_q_r[j]    <= kd_q_nxt[j];
      kd_sat_r[j]  <= kd_sat_nxt[j];
    end

    sidet_r <= kd_side_r[KD_STAGES-1];
    wm_r    <= GAUSS_TAB[kidx];

    ps_r <= sidet_r.ws * sidet_r.s;
    pm_r <= wm_r * sidet_r.m;
    pl_r <= sidet_r.wl * sidet_r.l;
    t_r  <= (W_W+2)'(sidet_r.ws) + (W_W+2)'(wm_r) + (W_W+2)'(sidet_r.wl);

    den_r <= den_nxt;
    num_r <= num_nxt;

    for (int j = 0; j < FD_STAGES; j++) begin
      fd_den_r[j] <= (j == 0) ? den_r : fd_den_r[(j == 0) ? 0 : j-1];
      fd_rem_r[j] <= fd_rem_nxt[j];
      fd_q_r[j]   <= fd_q_nxt[j];
    end
  end

  assign out_valid       = fd_v_r[FD_STAGES-1];
  assign out_fused_pixel = fd_q_r[FD_STAGES-1];

`ifndef SYNTH
  // Every accepted item comes out as a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##14 out_valid)
    else $error("result missing at expected latency");

  // No result without a matching item
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 14))
    else $error("result without accepted item");

  // Index divider leaves a proper remainder unless saturated
  a_kdiv_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (kd_v_r[KD_STAGES-1] && !kd_sat_r[KD_STAGES-1])
      |-> kd_rem_r[KD_STAGES-1] < KR_W'(kd_sp_r[KD_STAGES-1]))
    else $error("gaussian index divide out of range");

  // Final divider leaves a proper remainder
  a_fdiv_rem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> fd_rem_r[FD_STAGES-1] < FR_W'(fd_den_r[FD_STAGES-1]))
    else $error("fusion divide out of range");
`endif

endmodule

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hdrf_pkg::*;

  localparam int LATENCY = 14;
  localparam int N_RANDOM = 1800;
  localparam logic [63:0] PIX_MAX = 64'd65535;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [PIX_W-1:0] in_short_pixel = '0;
  logic [PIX_W-1:0] in_medium_pixel = '0;
  logic [PIX_W-1:0] in_long_pixel = '0;
  logic out_valid;
  logic [OUT_W-1:0] out_fused_pixel;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  three_exposure_hdr_fusion_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_short_pixel(in_short_pixel), .in_medium_pixel(in_medium_pixel),
    .in_long_pixel(in_long_pixel), .out_valid(out_valid),
    .out_fused_pixel(out_fused_pixel), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the registers
  logic [15:0] clip_thr, dark_thr, mid_pt, spread;
  logic [63:0] exp_tab [256];
  logic [OUT_W-1:0] fused_q[$];
  int n_err = 0;
  bit timed_out = 0;
  bit idle_off = 0;

  // exp(-k/32) table, rebuilt by the same fixed-point recurrence
  initial begin
    logic [63:0] a;
    a = 64'd1 << 30;
    for (int k = 0; k < 256; k++) begin
      exp_tab[k] = (a + (64'd1 << 13)) >> 14;
      a = (a * 64'd4162825044) >> 32;
    end
  end

  function automatic logic [OUT_W-1:0] fuse_pixel(logic [15:0] s, logic [15:0] m,
                                                   logic [15:0] l);
    logic [63:0] ws, wm, wl, d, sp, k, num, tot;
    ws = 0;
    wl = 0;
    if (s < clip_thr) ws = ((PIX_MAX - s) * 64'd65536) / PIX_MAX;
    if (l > dark_thr) wl = ({48'd0, l} * 64'd65536) / PIX_MAX;
    d = (m >= mid_pt) ? m - mid_pt : mid_pt - m;
    sp = (spread == 0) ? 64'd1 : {48'd0, spread};
    k = (64'd32 * d * d) / (sp * sp);
    if (k > 255) k = 255;
    wm = exp_tab[k[7:0]];
    num = ws * s + wm * m + wl * l;
    tot = ws + wm + wl;
    return OUT_W'((PIX_MAX * num) / (PIX_MAX * tot + num));
  endfunction

  task automatic note_mismatch(string what, longint exp_v, longint act_v);
    n_err++;
    if (n_err <= 10)
      $display("ERROR %s: expected %0d got %0d at %0t", what, exp_v, act_v, $realtime);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (fused_q.size() == 0) note_mismatch("unexpected pixel", -1, out_fused_pixel);
      else begin
        logic [OUT_W-1:0] e;
        e = fused_q.pop_front();
        if (e !== out_fused_pixel) note_mismatch("fused_pixel", e, out_fused_pixel);
      end
    end
  end

  task automatic random_gap();
    if (!idle_off && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SHORT_CLIP: clip_thr = v;
      REG_LONG_DARK: dark_thr = v;
      REG_MED_MID: mid_pt = v;
      REG_MED_SPREAD: spread = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // unknown index: predictor state stays as is
  task automatic write_bad_index(logic [IDX_W-1:0] idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // optional typed expectation; -1 means take the predictor's value
  task automatic send_pixel(logic [15:0] s, logic [15:0] m, logic [15:0] l,
                            int typed = -1);
    logic [OUT_W-1:0] p;
    p = fuse_pixel(s, m, l);
    if (typed >= 0 && p != typed) note_mismatch("predictor vs typed value", typed, p);
    start <= 1'b1;
    in_short_pixel <= s;
    in_medium_pixel <= m;
    in_long_pixel <= l;
    do @(posedge clk); while (busy);
    fused_q.push_back(p);
    if (!idle_off && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (fused_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  typedef struct {
    logic [15:0] s, m, l;
    int typed;
  } pix_row_t;

  pix_row_t dir_rows[$] = '{
    '{16'd0, 16'd0, 16'd0, 0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 32767},
    '{16'd0, 16'd32768, 16'hFFFF, -1},
    '{16'hFFFF, 16'd32768, 16'd0, -1},
    '{16'd59999, 16'd100, 16'd5000, -1},
    '{16'd60000, 16'd40000, 16'd5001, -1},
    '{16'd1234, 16'd32768, 16'd65000, -1},
    '{16'h5555, 16'hAAAA, 16'h5555, -1},
    '{16'hAAAA, 16'h5555, 16'hAAAA, -1},
    '{16'd30000, 16'd0, 16'd30000, -1}
  };

  initial begin
    #200ms;
    timed_out = 1;
    $display("three_exposure_hdr_fusion_core: mismatch");
    $finish;
  end

  initial begin
    clip_thr = RST_SHORT_CLIP;
    dark_thr = RST_LONG_DARK;
    mid_pt = RST_MED_MID;
    spread = RST_MED_SPREAD;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at reset settings
    foreach (dir_rows[i]) send_pixel(dir_rows[i].s, dir_rows[i].m, dir_rows[i].l,
                                     dir_rows[i].typed);
    drain();

    // extreme settings: zero spread, zero clip, top dark threshold, far midpoint, then the opposite corner
    write_reg(REG_MED_SPREAD, 16'd0);
    write_reg(REG_SHORT_CLIP, 16'd0);
    write_reg(REG_LONG_DARK, 16'hFFFF);
    write_reg(REG_MED_MID, 16'hFFFF);
    write_bad_index(8'd4, 16'd1);
    write_bad_index(8'hFF, 16'd7);
    send_pixel(16'd0, 16'd0, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'd0);
    send_pixel(16'd100, 16'hFFFE, 16'd200);
    drain();
    write_reg(REG_MED_SPREAD, 16'hFFFF);
    write_reg(REG_SHORT_CLIP, 16'hFFFF);
    write_reg(REG_LONG_DARK, 16'd0);
    write_reg(REG_MED_MID, 16'd0);
    send_pixel(16'hFFFE, 16'hFFFF, 16'd1);
    send_pixel(16'd0, 16'd0, 16'd0);
    send_pixel(16'd1, 16'd8000, 16'hFFFF);
    drain();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_SHORT_CLIP, 16'($urandom));
      write_reg(REG_LONG_DARK, 16'($urandom));
      write_reg(REG_MED_MID, 16'($urandom));
      write_reg(REG_MED_SPREAD, (ph == 0) ? 16'd1 : 16'($urandom_range(1, 65535)));
      if (ph == 5) idle_off = 1;
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        logic [15:0] m;
        // medium often near the midpoint so the Gaussian index is spread out
        m = ($urandom_range(0, 1)) ? 16'(mid_pt + 16'($urandom_range(0, 2 * 4096)) - 4096)
                                  : 16'($urandom);
        send_pixel(16'($urandom), m, 16'($urandom));
        random_gap();
      end
      drain();
    end

    if (n_err == 0 && !timed_out)
      $display("three_exposure_hdr_fusion_core: match");
    else
      $display("three_exposure_hdr_fusion_core: mismatch");
    $finish;
  end

endmodule

### sim.f
rtl/hdrf_pkg.sv
rtl/three_exposure_hdr_fusion_core.sv
tb/tb_top.sv
